// ===== rtl/aetc_pkg.sv =====
package aetc_pkg;

    // Command codes on the result channel
    typedef enum logic [2:0] {
        OP_GLYPH      = 3'd0,
        OP_ERASE_EOL  = 3'd1,
        OP_CLEAR_ROWS = 3'd2,
        OP_CLEAR_ALL  = 3'd3,
        OP_SCROLL_UP  = 3'd4
    } t_op;

    // One drawing command
    typedef struct packed {
        t_op        op;
        logic [7:0] cell_row;
        logic [7:0] cell_col;
        logic [7:0] row_stop;
        logic [6:0] glyph;
        logic       last;
    } t_cmd;

    // CSI parameter counter saturates here (counter is 4 bits)
    localparam logic [3:0] MAX_PARAMS = 4'd8;

    // Register map, word index = paddr[3:2]
    localparam int          ADDR_W      = 4;
    localparam logic [1:0]  REG_ENABLE  = 2'd0;
    localparam logic [1:0]  REG_COLUMNS = 2'd1;
    localparam logic [1:0]  REG_ROWS    = 2'd2;

    localparam logic [7:0]  COLUMNS_RST = 8'd80;
    localparam logic [7:0]  ROWS_RST    = 8'd25;

    // Byte codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_LBRKT = 8'h5B;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;

    function automatic t_cmd mk_cmd(input t_op op, input logic [7:0] row,
                                    input logic [7:0] col, input logic [7:0] stop,
                                    input logic [6:0] glyph);
        t_cmd c;
        c.op       = op;
        c.cell_row = row;
        c.cell_col = col;
        c.row_stop = stop;
        c.glyph    = glyph;
        c.last     = 1'b0;
        return c;
    endfunction

endpackage

// ===== rtl/ansi_escape_text_console_top.sv =====
// Path: a taken byte is held in the input register and decoded from there; its commands
//   are written into the command queue and offered on the output from the queue, the first
//   before the second.
// Throughput: one byte per cycle while the command queue has room for two commands; the
//   single output port and its four-entry command queue set the pace.
// Reset (i_rst_n low, synchronous): parser normal, parameters and cursor zero, queue empty,
//   console disabled, 80 columns by 25 rows.
module ansi_escape_text_console_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_char_in,
    // command output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_op,
    output logic [7:0]                  o_cell_row,
    output logic [7:0]                  o_cell_col,
    output logic [7:0]                  o_row_stop,
    output logic [6:0]                  o_glyph,
    output logic                        o_last,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aetc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2
    } t_mode;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       r_enable;
    logic [7:0] r_columns;
    logic [7:0] r_rows;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_columns <= aetc_pkg::COLUMNS_RST;
            r_rows    <= aetc_pkg::ROWS_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                aetc_pkg::REG_ENABLE:  r_enable  <= pwdata[0];
                aetc_pkg::REG_COLUMNS: r_columns <= pwdata[7:0];
                aetc_pkg::REG_ROWS:    r_rows    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            aetc_pkg::REG_ENABLE:  prdata = {31'd0, r_enable};
            aetc_pkg::REG_COLUMNS: prdata = {24'd0, r_columns};
            aetc_pkg::REG_ROWS:    prdata = {24'd0, r_rows};
            default:               prdata = 32'd0;
        endcase
    end

    // A zero geometry register counts as one
    logic [7:0] eff_cols;
    logic [7:0] eff_rows;
    logic [7:0] last_row;
    logic [7:0] last_col;

    assign eff_cols = (r_columns == 8'd0) ? 8'd1 : r_columns;
    assign eff_rows = (r_rows == 8'd0) ? 8'd1 : r_rows;
    assign last_row = eff_rows - 8'd1;
    assign last_col = eff_cols - 8'd1;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       r_in_vld;
    logic [7:0] r_in_char;
    logic       in_xfer;
    logic       fire;

    // Command queue occupancy
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_cnt;

    // Decode a held byte once the queue has room for two commands
    assign fire    = r_in_vld & (r_cnt <= 3'd2);
    assign o_stall = r_in_vld & ~fire;
    assign in_xfer = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_xfer | (r_in_vld & ~fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_char <= i_char_in;
        end
    end

    // ------------------------------------------------------------------
    // Parser and cursor state
    // ------------------------------------------------------------------
    t_mode       r_mode,  n_mode;
    logic [3:0]  r_pcnt,  n_pcnt;
    logic [15:0] r_p1,    n_p1;
    logic [15:0] r_p2,    n_p2;
    logic [7:0]  r_crow,  n_crow;
    logic [7:0]  r_ccol,  n_ccol;

    // Decode results
    aetc_pkg::t_cmd res0;
    aetc_pkg::t_cmd res1;
    logic [1:0]     res_n;

    // Helpers for the current byte
    logic [15:0] p0;
    logic [15:0] p1;
    logic [15:0] step;
    logic [15:0] hv;
    logic [16:0] sum_row;
    logic [16:0] sum_col;
    logic [15:0] acc1;
    logic [15:0] acc2;
    logic [3:0]  pcnt_inc;
    logic [8:0]  row9;
    logic [8:0]  col9;
    logic [8:0]  row_next;
    logic [6:0]  gcode;
    logic [3:0]  digit;
    logic        printable;
    aetc_pkg::t_cmd emit_a;
    aetc_pkg::t_cmd emit_b;
    logic           emit_a_en;
    logic           emit_b_en;

    assign digit     = r_in_char[3:0];
    assign p0        = (r_pcnt > 4'd0) ? r_p1 : 16'd0;
    assign p1        = (r_pcnt > 4'd1) ? r_p2 : 16'd0;
    assign step      = (p0 > 16'd0) ? p0 : 16'd1;
    assign sum_row   = {9'd0, r_crow} + {1'b0, step};
    assign sum_col   = {9'd0, r_ccol} + {1'b0, step};
    // x*10 + digit, wrapping at 16 bits
    assign acc1      = {r_p1[12:0], 3'b000} + {r_p1[14:0], 1'b0} + {12'd0, digit};
    assign acc2      = {r_p2[12:0], 3'b000} + {r_p2[14:0], 1'b0} + {12'd0, digit};
    assign pcnt_inc  = r_pcnt + 4'd1;
    assign row_next  = {1'b0, r_crow} + 9'd1;
    assign printable = (r_in_char >= aetc_pkg::CH_SPACE) && (r_in_char <= aetc_pkg::CH_TILDE);
    assign gcode     = printable ? r_in_char[6:0] : aetc_pkg::CH_QUEST[6:0];

    always_comb begin
        n_mode    = r_mode;
        n_pcnt    = r_pcnt;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_crow    = r_crow;
        n_ccol    = r_ccol;
        emit_a    = '0;
        emit_b    = '0;
        emit_a_en = 1'b0;
        emit_b_en = 1'b0;
        hv        = 16'd0;
        row9      = {1'b0, r_crow};
        col9      = {1'b0, r_ccol};

        if (r_enable) begin
            case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_NORMAL;
                    if (r_in_char == aetc_pkg::CH_LBRKT) begin
                        n_mode = MODE_CSI;
                        n_pcnt = 4'd0;
                        n_p1   = 16'd0;
                    end else if (r_in_char == aetc_pkg::CH_LC_C) begin
                        // full reset: clear screen, home cursor
                        emit_a    = aetc_pkg::mk_cmd(aetc_pkg::OP_CLEAR_ALL, 8'd0, 8'd0,
                                                     8'd0, 7'd0);
                        emit_a_en = 1'b1;
                        n_crow    = 8'd0;
                        n_ccol    = 8'd0;
                    end
                end

                MODE_CSI: begin
                    if (r_in_char inside {[aetc_pkg::CH_ZERO:aetc_pkg::CH_NINE]}) begin
                        if (r_pcnt == 4'd0 || r_pcnt == 4'd1) begin
                            n_pcnt = 4'd1;
                            n_p1   = acc1;
                        end else if (r_pcnt == 4'd2) begin
                            n_p2 = acc2;
                        end
                    end else if (r_in_char == aetc_pkg::CH_SEMI) begin
                        if (r_pcnt < aetc_pkg::MAX_PARAMS) begin
                            n_pcnt = pcnt_inc;
                            if (pcnt_inc == 4'd1) begin
                                n_p1 = 16'd0;
                            end else if (pcnt_inc == 4'd2) begin
                                n_p2 = 16'd0;
                            end
                        end
                    end else if (r_in_char == aetc_pkg::CH_QUEST ||
                                 r_in_char == aetc_pkg::CH_GT) begin
                        // private markers: swallowed
                    end else begin
                        n_mode = MODE_NORMAL;
                        case (r_in_char)
                            aetc_pkg::CH_J: begin
                                if (p0 == 16'd0) begin
                                    if (r_ccol < eff_cols) begin
                                        emit_a    = aetc_pkg::mk_cmd(aetc_pkg::OP_ERASE_EOL,
                                                        r_crow, r_ccol, 8'd0,
                                                        aetc_pkg::CH_SPACE[6:0]);
                                        emit_a_en = 1'b1;
                                    end
                                    if (row_next < {1'b0, eff_rows}) begin
                                        emit_b    = aetc_pkg::mk_cmd(aetc_pkg::OP_CLEAR_ROWS,
                                                        row_next[7:0], 8'd0, eff_rows, 7'd0);
                                        emit_b_en = 1'b1;
                                    end
                                end else if (p0 == 16'd2) begin
                                    emit_a    = aetc_pkg::mk_cmd(aetc_pkg::OP_CLEAR_ROWS,
                                                    8'd0, 8'd0, eff_rows, 7'd0);
                                    emit_a_en = 1'b1;
                                end
                            end
                            aetc_pkg::CH_K: begin
                                if (p0 == 16'd0) begin
                                    if (r_ccol < eff_cols) begin
                                        emit_a    = aetc_pkg::mk_cmd(aetc_pkg::OP_ERASE_EOL,
                                                        r_crow, r_ccol, 8'd0,
                                                        aetc_pkg::CH_SPACE[6:0]);
                                        emit_a_en = 1'b1;
                                    end
                                end else if (p0 == 16'd2) begin
                                    // stop wraps to 0 on row 255, as the field is 8 bits
                                    emit_a    = aetc_pkg::mk_cmd(aetc_pkg::OP_CLEAR_ROWS,
                                                    r_crow, 8'd0, row_next[7:0], 7'd0);
                                    emit_a_en = 1'b1;
                                end
                            end
                            aetc_pkg::CH_H, aetc_pkg::CH_LC_F: begin
                                hv     = (p0 > 16'd0) ? p0 - 16'd1 : 16'd0;
                                n_crow = (hv >= {8'd0, eff_rows}) ? last_row : hv[7:0];
                                hv     = (p1 > 16'd0) ? p1 - 16'd1 : 16'd0;
                                n_ccol = (hv >= {8'd0, eff_cols}) ? last_col : hv[7:0];
                            end
                            aetc_pkg::CH_A: begin
                                n_crow = ({8'd0, r_crow} > step) ? r_crow - step[7:0] : 8'd0;
                            end
                            aetc_pkg::CH_B: begin
                                n_crow = (sum_row >= {9'd0, eff_rows}) ? last_row
                                                                       : sum_row[7:0];
                            end
                            aetc_pkg::CH_C: begin
                                n_ccol = (sum_col >= {9'd0, eff_cols}) ? last_col
                                                                       : sum_col[7:0];
                            end
                            aetc_pkg::CH_D: begin
                                n_ccol = ({8'd0, r_ccol} > step) ? r_ccol - step[7:0] : 8'd0;
                            end
                            default: ;  // other finals, SGR, or an abort byte
                        endcase
                    end
                end

                default: begin
                    if (r_in_char == aetc_pkg::CH_ESC) begin
                        n_mode = MODE_ESC;
                    end else if (r_in_char == aetc_pkg::CH_CR) begin
                        n_ccol = 8'd0;
                    end else if (r_in_char == aetc_pkg::CH_BS) begin
                        if (r_ccol != 8'd0) begin
                            n_ccol    = r_ccol - 8'd1;
                            emit_a    = aetc_pkg::mk_cmd(aetc_pkg::OP_GLYPH, r_crow,
                                            r_ccol - 8'd1, 8'd0, aetc_pkg::CH_SPACE[6:0]);
                            emit_a_en = 1'b1;
                        end
                    end else begin
                        if (r_in_char == aetc_pkg::CH_LF) begin
                            col9 = 9'd0;
                            row9 = row_next;
                        end else begin
                            emit_a    = aetc_pkg::mk_cmd(aetc_pkg::OP_GLYPH, r_crow, r_ccol,
                                                         8'd0, gcode);
                            emit_a_en = 1'b1;
                            col9      = {1'b0, r_ccol} + 9'd1;
                            if (col9 >= {1'b0, eff_cols}) begin
                                col9 = 9'd0;
                                row9 = row_next;
                            end
                        end
                        // past the bottom (or a shrunk screen): scroll once
                        if (row9 >= {1'b0, eff_rows}) begin
                            row9      = {1'b0, last_row};
                            emit_b    = aetc_pkg::mk_cmd(aetc_pkg::OP_SCROLL_UP, last_row,
                                                         8'd0, 8'd0, 7'd0);
                            emit_b_en = 1'b1;
                        end
                        n_crow = row9[7:0];
                        n_ccol = col9[7:0];
                    end
                end
            endcase
        end
    end

    // Pack the commands, marking the final one of this byte
    always_comb begin
        res0  = '0;
        res1  = '0;
        res_n = 2'd0;
        if (emit_a_en && emit_b_en) begin
            res0      = emit_a;
            res1      = emit_b;
            res1.last = 1'b1;
            res_n     = 2'd2;
        end else if (emit_a_en) begin
            res0      = emit_a;
            res0.last = 1'b1;
            res_n     = 2'd1;
        end else if (emit_b_en) begin
            res0      = emit_b;
            res0.last = 1'b1;
            res_n     = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_pcnt <= 4'd0;
            r_p1   <= 16'd0;
            r_p2   <= 16'd0;
            r_crow <= 8'd0;
            r_ccol <= 8'd0;
        end else if (fire) begin
            r_mode <= n_mode;
            r_pcnt <= n_pcnt;
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_crow <= n_crow;
            r_ccol <= n_ccol;
        end
    end

    // ------------------------------------------------------------------
    // Command queue: four entries, up to two written per cycle, one read
    // ------------------------------------------------------------------
    aetc_pkg::t_cmd r_q [4];
    aetc_pkg::t_cmd q_head;
    logic           out_xfer;
    logic [1:0]     push_n;

    assign push_n   = fire ? res_n : 2'd0;
    assign q_head   = r_q[r_rd_ptr];
    assign o_valid  = (r_cnt != 3'd0);
    assign out_xfer = o_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wr_ptr + 2'd1] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_cnt    <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n;
            if (out_xfer) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, push_n} - {2'd0, out_xfer};
        end
    end

    assign o_op       = q_head.op;
    assign o_cell_row = q_head.cell_row;
    assign o_cell_col = q_head.cell_col;
    assign o_row_stop = q_head.row_stop;
    assign o_glyph    = q_head.glyph;
    assign o_last     = q_head.last;

endmodule

// ===== test/tb_ansi_escape_text_console_top.sv =====
`timescale 1ns / 1ps

module tb_ansi_escape_text_console_top;
    import aetc_pkg::*;

    // parser modes of the predictor
    typedef enum logic [1:0] {
        PM_NORMAL,
        PM_ESC,
        PM_CSI
    } t_pmode;

    // one row of the directed table; n_fixed < 0 means "ask the predictor"
    typedef struct {
        logic [7:0] ch;
        int         n_fixed;
        t_cmd       c0;
        t_cmd       c1;
    } t_dir_row;

    localparam int   PREDICTED     = -1;
    localparam t_cmd NO_CMD        = '0;
    localparam int   HOLD_CYCLES   = 200;   // long receiver hold-off
    localparam int   SETTLE_CYCLES = 6;     // byte decode + two queued commands
    localparam int   MAX_REPORTS   = 10;

    localparam logic [7:0] CH_LC_M = 8'h6D;
    localparam logic [7:0] CH_LC_X = 8'h78;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_char_in;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_op;
    logic [7:0]  o_cell_row;
    logic [7:0]  o_cell_col;
    logic [7:0]  o_row_stop;
    logic [6:0]  o_glyph;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // fixed expectation travelling alongside the byte on the input channel
    int          byte_nfix;
    t_cmd        byte_c0;
    t_cmd        byte_c1;

    // predictor copy of registers and parser/cursor state
    logic        con_en;
    logic [7:0]  scr_cols;
    logic [7:0]  scr_rows;
    t_pmode      pmode;
    logic [3:0]  pcount;
    logic [15:0] prm0;
    logic [15:0] prm1;
    logic [7:0]  crow;
    logic [7:0]  ccol;

    t_cmd        predicted_cmds[$];   // commands caused by the byte just taken
    t_cmd        pending_cmds[$];     // commands still owed by the block
    logic [7:0]  text_q[$];           // byte sequence about to be sent
    t_dir_row    dir_tab[$];

    int          n_err;
    int          sent_bytes;
    bit          idle_on;
    bit          hold_req;

    ansi_escape_text_console_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_char_in  (i_char_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_op       (o_op),
        .o_cell_row (o_cell_row),
        .o_cell_col (o_cell_col),
        .o_row_stop (o_row_stop),
        .o_glyph    (o_glyph),
        .o_last     (o_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic t_cmd cmd(input t_op op, input int row, input int col,
                                 input int stop_row, input int gl, input bit fin);
        t_cmd c;
        c.op       = op;
        c.cell_row = 8'(row);
        c.cell_col = 8'(col);
        c.row_stop = 8'(stop_row);
        c.glyph    = 7'(gl);
        c.last     = fin;
        return c;
    endfunction

    function automatic void erase_eol(input int eff_c);
        // nothing to blank when the cursor sits past the right edge
        if (int'(ccol) < eff_c)
            predicted_cmds.push_back(cmd(OP_ERASE_EOL, int'(crow), int'(ccol), 0,
                                         int'(CH_SPACE), 1'b0));
    endfunction

    function automatic void clear_span(input int first, input int stop_row);
        if (first < stop_row)
            predicted_cmds.push_back(cmd(OP_CLEAR_ROWS, first, 0, stop_row, 0, 1'b0));
    endfunction

    function automatic void csi_final(input logic [7:0] ch, input int eff_r, input int eff_c);
        int p0;
        int p1;
        int mv_step;
        int v;
        p0 = (pcount > 0) ? int'(prm0) : 0;
        p1 = (pcount > 1) ? int'(prm1) : 0;
        mv_step = (p0 > 0) ? p0 : 1;
        case (ch)
            CH_J: begin
                if (p0 == 0) begin
                    erase_eol(eff_c);
                    clear_span(int'(crow) + 1, eff_r);
                end else if (p0 == 2) begin
                    clear_span(0, eff_r);
                end
            end
            CH_K: begin
                if (p0 == 0)
                    erase_eol(eff_c);
                else if (p0 == 2)
                    clear_span(int'(crow), int'(crow) + 1);
            end
            CH_H, CH_LC_F: begin
                v = (p0 > 0) ? p0 - 1 : 0;
                crow = 8'((v >= eff_r) ? eff_r - 1 : v);
                v = (p1 > 0) ? p1 - 1 : 0;
                ccol = 8'((v >= eff_c) ? eff_c - 1 : v);
            end
            CH_A: crow = 8'((int'(crow) > mv_step) ? int'(crow) - mv_step : 0);
            CH_B: begin
                v = int'(crow) + mv_step;
                crow = 8'((v >= eff_r) ? eff_r - 1 : v);
            end
            CH_C: begin
                v = int'(ccol) + mv_step;
                ccol = 8'((v >= eff_c) ? eff_c - 1 : v);
            end
            CH_D: ccol = 8'((int'(ccol) > mv_step) ? int'(ccol) - mv_step : 0);
            default: ;
        endcase
    endfunction

    // works out the commands one accepted byte causes, advancing the state
    function automatic void console_predict(input logic [7:0] ch);
        int eff_c;
        int eff_r;
        int row;
        int col;
        predicted_cmds.delete();
        if (!con_en)
            return;
        eff_c = (scr_cols == 0) ? 1 : int'(scr_cols);
        eff_r = (scr_rows == 0) ? 1 : int'(scr_rows);
        case (pmode)
            PM_ESC: begin
                pmode = PM_NORMAL;
                if (ch == CH_LBRKT) begin
                    pmode  = PM_CSI;
                    pcount = '0;
                    prm0   = '0;
                end else if (ch == CH_LC_C) begin
                    predicted_cmds.push_back(cmd(OP_CLEAR_ALL, 0, 0, 0, 0, 1'b0));
                    crow = '0;
                    ccol = '0;
                end
            end
            PM_CSI: begin
                if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    if (pcount == 0)
                        pcount = 4'd1;
                    if (pcount == 1)
                        prm0 = prm0 * 16'd10 + {12'd0, ch[3:0]};
                    else if (pcount == 2)
                        prm1 = prm1 * 16'd10 + {12'd0, ch[3:0]};
                end else if (ch == CH_SEMI) begin
                    if (pcount < MAX_PARAMS) begin
                        pcount++;
                        if (pcount == 1)
                            prm0 = '0;
                        else if (pcount == 2)
                            prm1 = '0;
                    end
                end else if (ch != CH_QUEST && ch != CH_GT) begin
                    pmode = PM_NORMAL;
                    if (ch >= CH_AT && ch <= CH_TILDE)
                        csi_final(ch, eff_r, eff_c);
                end
            end
            default: begin
                if (ch == CH_ESC) begin
                    pmode = PM_ESC;
                end else if (ch == CH_CR) begin
                    ccol = '0;
                end else if (ch == CH_BS) begin
                    if (ccol > 0) begin
                        ccol--;
                        predicted_cmds.push_back(cmd(OP_GLYPH, int'(crow), int'(ccol), 0,
                                                     int'(CH_SPACE), 1'b0));
                    end
                end else begin
                    row = int'(crow);
                    col = int'(ccol);
                    if (ch == CH_LF) begin
                        col = 0;
                        row++;
                    end else begin
                        predicted_cmds.push_back(cmd(OP_GLYPH, row, col, 0,
                            (ch < CH_SPACE || ch > CH_TILDE) ? int'(CH_QUEST) : int'(ch),
                            1'b0));
                        col++;
                        if (col >= eff_c) begin
                            col = 0;
                            row++;
                        end
                    end
                    // also catches a cursor left below a shrunk screen
                    if (row >= eff_r) begin
                        row = eff_r - 1;
                        predicted_cmds.push_back(cmd(OP_SCROLL_UP, row, 0, 0, 0, 1'b0));
                    end
                    crow = 8'(row);
                    ccol = 8'(col);
                end
            end
        endcase
        if (predicted_cmds.size() > 0)
            predicted_cmds[predicted_cmds.size() - 1].last = 1'b1;
    endfunction

    function automatic string show(input t_cmd c);
        return $sformatf("op=%0d row=%0d col=%0d stop=%0d glyph=%0d last=%0d",
                         c.op, c.cell_row, c.cell_col, c.row_stop, c.glyph, c.last);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: register writes, byte transfers and command transfers, all
    // sampled at the rising edge so nothing hangs on event order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cmd got;
        t_cmd want;
        if (!i_rst_n) begin
            con_en   = 1'b0;
            scr_cols = COLUMNS_RST;
            scr_rows = ROWS_RST;
            pmode    = PM_NORMAL;
            pcount   = '0;
            prm0     = '0;
            prm1     = '0;
            crow     = '0;
            ccol     = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ENABLE:  con_en   = pwdata[0];
                    REG_COLUMNS: scr_cols = pwdata[7:0];
                    REG_ROWS:    scr_rows = pwdata[7:0];
                    default: ;
                endcase
            end

            if (i_valid && !o_stall) begin
                // the predictor always runs so its state keeps step
                console_predict(i_char_in);
                if (byte_nfix >= 0) begin
                    if (byte_nfix > 0)
                        pending_cmds.push_back(byte_c0);
                    if (byte_nfix > 1)
                        pending_cmds.push_back(byte_c1);
                end else begin
                    foreach (predicted_cmds[k])
                        pending_cmds.push_back(predicted_cmds[k]);
                end
            end

            if (o_valid && !i_stall) begin
                got.op       = t_op'(o_op);
                got.cell_row = o_cell_row;
                got.cell_col = o_cell_col;
                got.row_stop = o_row_stop;
                got.glyph    = o_glyph;
                got.last     = o_last;
                if (pending_cmds.size() == 0) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("unexpected command: %s", show(got));
                end else begin
                    want = pending_cmds.pop_front();
                    if (got.op !== want.op || got.cell_row !== want.cell_row ||
                        got.cell_col !== want.cell_col || got.row_stop !== want.row_stop ||
                        got.glyph !== want.glyph || got.last !== want.last) begin
                        n_err++;
                        if (n_err <= MAX_REPORTS)
                            $display("command mismatch\n  exp %s\n  got %s",
                                     show(want), show(got));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // offers one byte; returns in the step where the transfer happened
    task automatic send_byte(input logic [7:0] ch, input int nfix,
                             input t_cmd c0, input t_cmd c1);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= ch;
        byte_nfix <= nfix;
        byte_c0   <= c0;
        byte_c1   <= c1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_text();
        while (text_q.size() != 0)
            send_byte(text_q.pop_front(), PREDICTED, NO_CMD, NO_CMD);
    endtask

    // stop offering, wait for every owed command, then let the pipe settle
    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_cmds.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void push_num(input int v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    // CSI parameter: mostly small, sometimes past the 16-bit wrap
    function automatic int param_val();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return $urandom_range(0, 3);
        else if (r < 17)
            return $urandom_range(0, 300);
        return $urandom_range(0, 999999);
    endfunction

    // one random token: text, controls, noise, or an escape sequence
    function automatic void gen_token();
        int pick;
        int np;
        int r;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            text_q.push_back(8'($urandom_range(32, 126)));
        end else if (pick < 50) begin
            r = $urandom_range(0, 2);
            text_q.push_back((r == 0) ? CH_CR : (r == 1) ? CH_LF : CH_BS);
        end else if (pick < 56) begin
            text_q.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 60) begin
            text_q.push_back(CH_ESC);
            text_q.push_back(CH_LC_C);
        end else if (pick < 63) begin
            text_q.push_back(CH_ESC);
            text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            text_q.push_back(CH_ESC);
            text_q.push_back(CH_LBRKT);
            if ($urandom_range(0, 7) == 0)
                text_q.push_back($urandom_range(0, 1) ? CH_QUEST : CH_GT);
            // now and then more parameters than the counter keeps
            np = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 11) : $urandom_range(0, 2);
            for (int i = 0; i < np; i++) begin
                if (i > 0)
                    text_q.push_back(CH_SEMI);
                if ($urandom_range(0, 5) != 0)
                    push_num(param_val());
            end
            r = $urandom_range(0, 19);
            case (r)
                0, 1:   b = CH_J;
                2, 3:   b = CH_K;
                4:      b = CH_H;
                5:      b = CH_LC_F;
                6, 7:   b = CH_A;
                8, 9:   b = CH_B;
                10, 11: b = CH_C;
                12, 13: b = CH_D;
                14:     b = CH_LC_M;
                15, 16: b = 8'($urandom_range(CH_AT, CH_TILDE));
                default: begin
                    // abort byte: neither parameter, marker nor final
                    do
                        b = 8'($urandom_range(0, 255));
                    while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI ||
                           b == CH_QUEST || b == CH_GT || (b >= CH_AT && b <= CH_TILDE));
                end
            endcase
            text_q.push_back(b);
        end
    endfunction

    task automatic run_phase(input int ncols, input int nrows, input int nbytes,
                             input bit with_hold);
        int stop_at;
        drain_results();
        reg_write(REG_COLUMNS, 32'(ncols));
        reg_write(REG_ROWS, 32'(nrows));
        if (with_hold)
            hold_req = 1'b1;
        stop_at = sent_bytes + nbytes;
        while (sent_bytes < stop_at) begin
            gen_token();
            send_text();
        end
    endtask

    function automatic t_dir_row dir_row(input logic [7:0] ch, input int n,
                                         input t_cmd c0, input t_cmd c1);
        t_dir_row d;
        d.ch      = ch;
        d.n_fixed = n;
        d.c0      = c0;
        d.c1      = c1;
        return d;
    endfunction

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_char_in <= '0;
        byte_nfix <= PREDICTED;
        byte_c0   <= NO_CMD;
        byte_c1   <= NO_CMD;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        n_err      = 0;
        sent_bytes = 0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;

        // Directed table, 80x25 from reset. Rows with a count carry their
        // commands typed in; the rest go through the predictor.
        dir_tab.push_back(dir_row(CH_A, 1, cmd(OP_GLYPH, 0, 0, 0, int'(CH_A), 1'b1), NO_CMD));
        dir_tab.push_back(dir_row(8'h00, 1, cmd(OP_GLYPH, 0, 1, 0, int'(CH_QUEST), 1'b1),
                                  NO_CMD));
        dir_tab.push_back(dir_row(8'hFF, 1, cmd(OP_GLYPH, 0, 2, 0, int'(CH_QUEST), 1'b1),
                                  NO_CMD));
        dir_tab.push_back(dir_row(CH_TILDE, 1, cmd(OP_GLYPH, 0, 3, 0, int'(CH_TILDE), 1'b1),
                                  NO_CMD));
        dir_tab.push_back(dir_row(CH_BS, 1, cmd(OP_GLYPH, 0, 3, 0, int'(CH_SPACE), 1'b1),
                                  NO_CMD));
        dir_tab.push_back(dir_row(CH_CR, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_BS, 0, NO_CMD, NO_CMD));    // already at column 0
        dir_tab.push_back(dir_row(CH_LF, 0, NO_CMD, NO_CMD));
        // CSI > 9 ; 99 f : private marker, column clamps to the right edge
        dir_tab.push_back(dir_row(CH_ESC, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_LBRKT, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_GT, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_NINE, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_SEMI, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_NINE, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_NINE, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_LC_F, PREDICTED, NO_CMD, NO_CMD));
        // unknown escape swallows the next byte
        dir_tab.push_back(dir_row(CH_ESC, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_LC_X, 0, NO_CMD, NO_CMD));
        // CSI 0 J at row 8, col 79: erase to row end, then rows 9..24
        dir_tab.push_back(dir_row(CH_ESC, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_LBRKT, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_ZERO, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_J, 2,
                                  cmd(OP_ERASE_EOL, 8, 79, 0, int'(CH_SPACE), 1'b0),
                                  cmd(OP_CLEAR_ROWS, 9, 0, 25, 0, 1'b1)));
        // RIS
        dir_tab.push_back(dir_row(CH_ESC, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_LC_C, 1, cmd(OP_CLEAR_ALL, 0, 0, 0, 0, 1'b1), NO_CMD));
        // CSI 2 J: whole screen
        dir_tab.push_back(dir_row(CH_ESC, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_LBRKT, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(8'h32, 0, NO_CMD, NO_CMD));
        dir_tab.push_back(dir_row(CH_J, 1, cmd(OP_CLEAR_ROWS, 0, 0, 25, 0, 1'b1), NO_CMD));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // console is off after reset: these bytes must vanish
        send_byte(CH_A, 0, NO_CMD, NO_CMD);
        send_byte(CH_ESC, 0, NO_CMD, NO_CMD);
        send_byte(CH_LC_C, 0, NO_CMD, NO_CMD);
        drain_results();
        reg_write(REG_ENABLE, 32'd1);

        foreach (dir_tab[k])
            send_byte(dir_tab[k].ch, dir_tab[k].n_fixed, dir_tab[k].c0, dir_tab[k].c1);

        // reset geometry, with the long hold-off filling the command queue
        run_phase(80, 25, 250, 1'b1);

        // open a CSI, switch the console off mid-sequence, feed noise,
        // then finish the sequence once it is back on
        text_q.push_back(CH_ESC);
        text_q.push_back(CH_LBRKT);
        text_q.push_back(8'h33);
        send_text();
        drain_results();
        reg_write(REG_ENABLE, 32'd0);
        repeat (30)
            send_byte(8'($urandom_range(0, 255)), 0, NO_CMD, NO_CMD);
        drain_results();
        reg_write(REG_ENABLE, 32'd1);
        send_byte(CH_C, PREDICTED, NO_CMD, NO_CMD);

        run_phase(1, 1, 100, 1'b0);
        run_phase(255, 255, 150, 1'b0);
        // park the cursor far out before the screen shrinks
        text_q.push_back(CH_ESC);
        text_q.push_back(CH_LBRKT);
        push_num(200);
        text_q.push_back(CH_SEMI);
        push_num(250);
        text_q.push_back(CH_H);
        send_text();
        run_phase(8, 4, 150, 1'b0);
        run_phase(0, 0, 80, 1'b0);   // zero geometry behaves as 1x1

        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        run_phase(40, 12, 300, 1'b0);
        drain_results();

        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
